// File: hw/rtl/pllm_pkg.sv
// ----------------------------------------------------------------------------
// pllm_pkg
// Shared types and codes of the pooled linked list manager: operation and
// status codes, field widths and the node record kept in the node memory.
// ----------------------------------------------------------------------------
package pllm_pkg;

   localparam int POOL_NODES_DEF = 16;

   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int NODE_W   = 4;
   localparam int LINK_W   = 5;
   localparam int NAME_W   = 64;
   localparam int TOP_W    = 32;
   localparam int VALUE_W  = 32;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NO_SUCC = 2'd3;

   typedef struct packed {
      logic [NAME_W-1:0]         name_a;
      logic [NAME_W-1:0]         name_b;
      logic [TOP_W-1:0]          name_c;
      logic signed [VALUE_W-1:0] weight;
      logic signed [VALUE_W-1:0] cost;
   } node_data_type;

   // Contents of a node that is free: empty name, weight and cost of -1.
   localparam node_data_type NODE_CLEAR = '{
      name_a: '0,
      name_b: '0,
      name_c: '0,
      weight: '1,
      cost:   '1
   };

endpackage

// File: hw/rtl/pooled_linked_list_manager.sv
// ----------------------------------------------------------------------------
// pooled_linked_list_manager
// One singly linked list and a free list kept in a fixed pool of nodes. The
// node records and the next links live in two synchronous memories.
// ----------------------------------------------------------------------------
//  Channel   Ports              Transaction
//  request   start/busy, req_*  taken at an edge with start high and busy low
//  response  rsp_strobe, rsp_*  shown for one cycle, taken at its closing edge
//
//  Read, insert at head, delete at head and every failed or idle command pass
//  through ST_EXEC alone before ST_IDLE; insert after a node adds ST_FIX and
//  delete after a node adds ST_CHASE and ST_FIX, set by the dependent reads and
//  the single write port of the link memory. After reset a clearing pass
//  rebuilds the whole pool with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module pooled_linked_list_manager
   import pllm_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic                       req_at_head,
   input  logic [NODE_W-1:0]          req_node_index,
   input  logic [NAME_W-1:0]          req_name_a,
   input  logic [NAME_W-1:0]          req_name_b,
   input  logic [TOP_W-1:0]           req_name_c,
   input  logic signed [VALUE_W-1:0]  req_weight_in,
   input  logic signed [VALUE_W-1:0]  req_cost_in,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [NODE_W-1:0]          rsp_touched_node,
   output logic [NAME_W-1:0]          rsp_out_name_a,
   output logic [NAME_W-1:0]          rsp_out_name_b,
   output logic [TOP_W-1:0]           rsp_out_name_c,
   output logic signed [VALUE_W-1:0]  rsp_out_weight,
   output logic signed [VALUE_W-1:0]  rsp_out_cost,
   output logic signed [LINK_W-1:0]   rsp_out_link,
   output logic signed [LINK_W-1:0]   rsp_list_head,
   output logic signed [LINK_W-1:0]   rsp_free_head
);

   localparam int IX_W  = $clog2(POOL_NODES);
   localparam int LK_W  = IX_W + 1;
   localparam logic [IX_W-1:0] LAST_IX  = IX_W'(POOL_NODES - 1);
   localparam logic [10:0]     POOL_CNT = 11'(POOL_NODES);
   localparam logic [LK_W-1:0] NO_LINK  = '1;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_CHASE = 3'd3;
   localparam logic [2:0] ST_FIX   = 3'd4;

   // A node index beyond the pool wraps around it.
   function automatic logic [IX_W-1:0] pool_index(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] r;
      logic [31:0]       w;
      r = n;
      for (int k = 0; k < 8; k++) begin
         if ({7'b0, r} >= POOL_CNT) begin
            r = r - POOL_CNT[NODE_W-1:0];
         end
      end
      w = {28'b0, r};
      return w[IX_W-1:0];
   endfunction

   function automatic logic [LINK_W-1:0] link_port(input logic [LK_W-1:0] l);
      logic [31:0] w;
      w = {{(32-LK_W){l[LK_W-1]}}, l};
      return w[LINK_W-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] node_port(input logic [IX_W-1:0] t);
      logic [31:0] w;
      w = {{(32-IX_W){1'b0}}, t};
      return w[NODE_W-1:0];
   endfunction

   logic [LK_W-1:0] link_mem [POOL_NODES];
   node_data_type   node_mem [POOL_NODES];

   logic [2:0]          state_ff, state_in;
   logic [LK_W-1:0]     head_ff, head_in;
   logic [LK_W-1:0]     free_ff, free_in;
   logic [IX_W-1:0]     init_ff, init_in;
   logic [IX_W-1:0]     tgt_ff, tgt_in;
   logic [LK_W-1:0]     lnk_ff, lnk_in;
   logic [ACTION_W-1:0] op_ff;
   logic                at_head_ff;
   logic [IX_W-1:0]     idx_ff;
   node_data_type       data_ff;

   logic [LK_W-1:0] lk_rd_a_ff, lk_rd_b_ff;
   node_data_type   dt_rd_ff;

   logic [IX_W-1:0] idx_in;
   logic [IX_W-1:0] ra_a;
   logic            lk_we;
   logic [IX_W-1:0] lk_wa;
   logic [LK_W-1:0] lk_wd;
   logic            dt_we;
   logic [IX_W-1:0] dt_wa;
   node_data_type   dt_wd;
   logic            accept;

   logic            fin;
   logic [STATUS_W-1:0] r_status;
   logic            r_node_ok;
   logic [IX_W-1:0] r_touched;
   node_data_type   r_data;
   logic [LK_W-1:0] r_link;

   logic                      rsp_strobe_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [NODE_W-1:0]         rsp_touched_ff;
   node_data_type             rsp_data_ff;
   logic [LINK_W-1:0]         rsp_link_ff;
   logic [LINK_W-1:0]         rsp_head_ff;
   logic [LINK_W-1:0]         rsp_free_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign idx_in = pool_index(req_node_index);

   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_wa] <= lk_wd;
      end
      lk_rd_a_ff <= link_mem[ra_a];
      lk_rd_b_ff <= link_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (dt_we) begin
         node_mem[dt_wa] <= dt_wd;
      end
      dt_rd_ff <= node_mem[idx_in];
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      init_in   = init_ff;
      tgt_in    = tgt_ff;
      lnk_in    = lnk_ff;
      ra_a      = idx_in;
      lk_we     = 1'b0;
      lk_wa     = tgt_ff;
      lk_wd     = free_ff;
      dt_we     = 1'b0;
      dt_wa     = tgt_ff;
      dt_wd     = NODE_CLEAR;
      fin       = 1'b0;
      r_status  = STS_OK;
      r_node_ok = 1'b0;
      r_touched = tgt_ff;
      r_data    = NODE_CLEAR;
      r_link    = free_ff;

      case (state_ff)
         ST_INIT: begin
            lk_we   = 1'b1;
            lk_wa   = init_ff;
            lk_wd   = (init_ff == LAST_IX) ? NO_LINK : {1'b0, init_ff + 1'b1};
            dt_we   = 1'b1;
            dt_wa   = init_ff;
            init_in = init_ff + 1'b1;
            if (init_ff == LAST_IX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Fetch the link that the command will follow first.
            ra_a = (req_action == ACT_INSERT) ? free_ff[IX_W-1:0] : head_ff[IX_W-1:0];
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               ACT_INSERT: begin
                  if (free_ff[LK_W-1]) begin
                     fin      = 1'b1;
                     r_status = STS_FULL;
                  end else begin
                     tgt_in  = free_ff[IX_W-1:0];
                     lk_we   = 1'b1;
                     lk_wa   = free_ff[IX_W-1:0];
                     dt_we   = 1'b1;
                     dt_wa   = free_ff[IX_W-1:0];
                     dt_wd   = data_ff;
                     free_in = lk_rd_a_ff;
                     if (at_head_ff) begin
                        lk_wd     = head_ff;
                        head_in   = free_ff;
                        fin       = 1'b1;
                        r_node_ok = 1'b1;
                        r_touched = free_ff[IX_W-1:0];
                        r_data    = data_ff;
                        r_link    = head_ff;
                     end else begin
                        lk_wd    = lk_rd_b_ff;
                        lnk_in   = lk_rd_b_ff;
                        state_in = ST_FIX;
                     end
                  end
               end
               ACT_DELETE: begin
                  if (head_ff[LK_W-1]) begin
                     fin      = 1'b1;
                     r_status = STS_EMPTY;
                  end else if (at_head_ff) begin
                     lk_we     = 1'b1;
                     lk_wa     = head_ff[IX_W-1:0];
                     lk_wd     = free_ff;
                     dt_we     = 1'b1;
                     dt_wa     = head_ff[IX_W-1:0];
                     head_in   = lk_rd_a_ff;
                     free_in   = head_ff;
                     fin       = 1'b1;
                     r_node_ok = 1'b1;
                     r_touched = head_ff[IX_W-1:0];
                     r_link    = free_ff;
                  end else if (lk_rd_b_ff[LK_W-1]) begin
                     fin      = 1'b1;
                     r_status = STS_NO_SUCC;
                  end else begin
                     // The successor's own link is needed before unlinking it.
                     tgt_in   = lk_rd_b_ff[IX_W-1:0];
                     ra_a     = lk_rd_b_ff[IX_W-1:0];
                     state_in = ST_CHASE;
                  end
               end
               ACT_READ: begin
                  fin       = 1'b1;
                  r_node_ok = 1'b1;
                  r_touched = idx_ff;
                  r_data    = dt_rd_ff;
                  r_link    = lk_rd_b_ff;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_CHASE: begin
            lk_we    = 1'b1;
            lk_wa    = idx_ff;
            lk_wd    = lk_rd_a_ff;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            fin       = 1'b1;
            r_node_ok = 1'b1;
            lk_we     = 1'b1;
            if (op_ff == ACT_INSERT) begin
               lk_wa  = idx_ff;
               lk_wd  = {1'b0, tgt_ff};
               r_data = data_ff;
               // A predecessor equal to the new node ends up linking to itself.
               r_link = (idx_ff == tgt_ff) ? {1'b0, tgt_ff} : lnk_ff;
            end else begin
               dt_we   = 1'b1;
               free_in = {1'b0, tgt_ff};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         head_ff       <= NO_LINK;
         free_ff       <= '0;
         init_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         free_ff       <= free_in;
         init_ff       <= init_in;
         rsp_strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      lnk_ff <= lnk_in;
      if (accept) begin
         op_ff      <= req_action;
         at_head_ff <= req_at_head;
         idx_ff     <= idx_in;
         data_ff    <= '{
            name_a: req_name_a,
            name_b: req_name_b,
            name_c: req_name_c,
            weight: req_weight_in,
            cost:   req_cost_in
         };
      end
      if (fin) begin
         rsp_status_ff  <= r_status;
         rsp_touched_ff <= r_node_ok ? node_port(r_touched) : '0;
         rsp_data_ff    <= r_node_ok ? r_data : '0;
         rsp_link_ff    <= r_node_ok ? link_port(r_link) : '0;
         rsp_head_ff    <= link_port(head_in);
         rsp_free_ff    <= link_port(free_in);
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_touched_node = rsp_touched_ff;
   assign rsp_out_name_a   = rsp_data_ff.name_a;
   assign rsp_out_name_b   = rsp_data_ff.name_b;
   assign rsp_out_name_c   = rsp_data_ff.name_c;
   assign rsp_out_weight   = rsp_data_ff.weight;
   assign rsp_out_cost     = rsp_data_ff.cost;
   assign rsp_out_link     = rsp_link_ff;
   assign rsp_list_head    = rsp_head_ff;
   assign rsp_free_head    = rsp_free_ff;

endmodule
